/* sv/integral_image_window_sum_defines.svh */
// Assertion macros shared by the summed-area table box sum RTL.
`ifndef INTEGRAL_IMAGE_WINDOW_SUM_DEFINES_SVH
`define INTEGRAL_IMAGE_WINDOW_SUM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-edge check: the property must hold at each sampled edge.
`define IIWS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("iiws assertion failed");
// Next-cycle implication: when ante holds, cons must hold after it (ante |=> cons).
`define IIWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("iiws assertion failed");
`else
`define IIWS_ASSERT(lbl, clk, rstn, prop)
`define IIWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* sv/iiws_pkg.sv */
// Package: constants, types and codes of the summed-area table box sum block.
`timescale 1ns / 1ps
package iiws_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int SUM_BITS    = 32;

    localparam int DIM_W       = 9;   // image / window size registers
    localparam int COORD_W     = 8;   // query coordinates, window half sizes
    localparam int PIX_W       = 8;
    localparam int POW_W       = 2 * PIX_W;
    localparam int ROWSUM_W    = 24;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int DEPTH       = MAX_WIDTH * MAX_HEIGHT;

    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd4;

    localparam logic [1:0] EXP_SQUARE = 2'd2;
    localparam logic       FUNC_QUERY = 1'b1;

    // Clamped, decoded configuration
    typedef struct packed {
        logic               exp2;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] half_w;
        logic [COORD_W-1:0] half_h;
    } t_cfg;

    // Decoded item passed from front to back. Corners are 1-based table coordinates.
    typedef struct packed {
        logic             is_query;
        logic             oob;
        logic [POW_W-1:0] pw;
        logic [DIM_W-1:0] rlo;
        logic [DIM_W-1:0] rhi;
        logic [DIM_W-1:0] clo;
        logic [DIM_W-1:0] chi;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QRD1,
        S_QRD2,
        S_QRD3,
        S_QFIN,
        S_LRD,
        S_LWR
    } t_state;

endpackage

/* sv/iiws_front.sv */
// Front end: classifies items, powers load pixels, clamps query windows.
`timescale 1ns / 1ps
module iiws_front (
    input  iiws_pkg::t_cfg                 i_cfg,
    input  logic                           i_func,
    input  logic [iiws_pkg::PIX_W-1:0]     i_pixel_value,
    input  logic [iiws_pkg::COORD_W-1:0]   i_query_row,
    input  logic [iiws_pkg::COORD_W-1:0]   i_query_col,
    output iiws_pkg::t_cmd                 o_cmd
);
    import iiws_pkg::*;

    logic [DIM_W-1:0] row, col, half_h, half_w;
    logic [DIM_W:0]   row_top, col_top;
    logic [POW_W-1:0] square;

    assign row    = DIM_W'(i_query_row);
    assign col    = DIM_W'(i_query_col);
    assign half_h = DIM_W'(i_cfg.half_h);
    assign half_w = DIM_W'(i_cfg.half_w);

    // one past the last window row / column, before clamping
    assign row_top = (DIM_W+1)'(row) + (DIM_W+1)'(half_h) + 1'b1;
    assign col_top = (DIM_W+1)'(col) + (DIM_W+1)'(half_w) + 1'b1;

    assign square = POW_W'(i_pixel_value) * POW_W'(i_pixel_value);

    always_comb begin
        o_cmd.is_query = (i_func == FUNC_QUERY);
        o_cmd.oob      = (row >= i_cfg.height) || (col >= i_cfg.width);
        o_cmd.pw       = i_cfg.exp2 ? square : POW_W'(i_pixel_value);
        o_cmd.rlo      = (row > half_h) ? row - half_h : '0;
        o_cmd.clo      = (col > half_w) ? col - half_w : '0;
        o_cmd.rhi      = (row_top > (DIM_W+1)'(i_cfg.height)) ? i_cfg.height
                                                              : row_top[DIM_W-1:0];
        o_cmd.chi      = (col_top > (DIM_W+1)'(i_cfg.width)) ? i_cfg.width
                                                             : col_top[DIM_W-1:0];
    end

endmodule

/* sv/iiws_queue.sv */
// Short command queue between the front end and the table engine.
`timescale 1ns / 1ps
`include "integral_image_window_sum_defines.svh"
module iiws_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  iiws_pkg::t_cmd  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output iiws_pkg::t_cmd  o_data
);
    import iiws_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `IIWS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH))
    `IIWS_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && !push, r_count == $past(r_count) - 1'b1)

endmodule

/* sv/iiws_back.sv */
// Table engine: builds the summed-area table and answers window queries.
`timescale 1ns / 1ps
`include "integral_image_window_sum_defines.svh"
module iiws_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  iiws_pkg::t_cfg                  i_cfg,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  iiws_pkg::t_cmd                  i_cmd,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [iiws_pkg::SUM_BITS-1:0]   o_window_sum,
    output logic                            o_out_of_image
);
    import iiws_pkg::*;

    logic [SUM_BITS-1:0] r_table [DEPTH];
    logic [SUM_BITS-1:0] r_rd_data;
    logic                r_rd_zero;

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [SUM_BITS-1:0] r_acc;
    logic [ROW_W-1:0]    r_lrow;
    logic [COL_W-1:0]    r_lcol;
    logic [ROWSUM_W-1:0] r_rowsum;
    logic                r_out_valid;
    logic [SUM_BITS-1:0] r_out_sum;
    logic                r_out_oob;

    logic                rd_en, wr_en, out_fire, pop, pop_load;
    logic [DIM_W-1:0]    rd_y, rd_x, rd_y_m1, rd_x_m1;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic                rd_zero;
    logic [SUM_BITS-1:0] rd_val, wr_data;

    // load pointer fix-up at pop time (image size may have shrunk)
    logic [ROW_W-1:0]    row_a, norm_row;
    logic [COL_W-1:0]    norm_col;
    logic [ROWSUM_W-1:0] norm_sum;
    logic [DIM_W-1:0]    row_a_inc, col_inc, row_inc;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        rd_y     = '0;
        rd_x     = '0;
        wr_en    = 1'b0;
        out_fire = 1'b0;
        o_q_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    if (i_cmd.is_query) begin
                        if (i_cmd.oob) begin
                            n_state = S_QFIN;
                        end else begin
                            rd_en   = 1'b1;
                            rd_y    = i_cmd.rhi;
                            rd_x    = i_cmd.chi;
                            n_state = S_QRD1;
                        end
                    end else begin
                        n_state = S_LRD;
                    end
                end
            end
            S_QRD1: begin
                rd_en   = 1'b1;
                rd_y    = r_cmd.rlo;
                rd_x    = r_cmd.chi;
                n_state = S_QRD2;
            end
            S_QRD2: begin
                rd_en   = 1'b1;
                rd_y    = r_cmd.rhi;
                rd_x    = r_cmd.clo;
                n_state = S_QRD3;
            end
            S_QRD3: begin
                rd_en   = 1'b1;
                rd_y    = r_cmd.rlo;
                rd_x    = r_cmd.clo;
                n_state = S_QFIN;
            end
            S_QFIN: begin
                out_fire = !r_out_valid || i_out_ready;
                if (out_fire) begin
                    n_state = S_IDLE;
                end
            end
            S_LRD: begin
                // entry above: 1-based (row, col + 1), zero on the first row
                rd_en   = 1'b1;
                rd_y    = DIM_W'(r_lrow);
                rd_x    = DIM_W'(r_lcol) + 1'b1;
                n_state = S_LWR;
            end
            S_LWR: begin
                wr_en   = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign pop      = o_q_ready && i_q_valid;
    assign pop_load = pop && !i_cmd.is_query;

    // ---------------- table addressing ----------------
    assign rd_zero = (rd_y == '0) || (rd_x == '0);
    assign rd_y_m1 = rd_y - 1'b1;
    assign rd_x_m1 = rd_x - 1'b1;
    assign rd_addr = {rd_y_m1[ROW_W-1:0], rd_x_m1[COL_W-1:0]};
    assign wr_addr = {r_lrow, r_lcol};
    assign rd_val  = r_rd_zero ? '0 : r_rd_data;
    assign wr_data = SUM_BITS'(r_cmd.pw) + rd_val + SUM_BITS'(r_rowsum);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
            r_rd_zero <= rd_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
    end

    // ---------------- load pointer ----------------
    always_comb begin
        row_a     = (DIM_W'(r_lrow) >= i_cfg.height) ? '0 : r_lrow;
        row_a_inc = DIM_W'(row_a) + 1'b1;
        norm_row  = row_a;
        norm_col  = r_lcol;
        norm_sum  = r_rowsum;
        if (DIM_W'(r_lcol) >= i_cfg.width) begin
            norm_col = '0;
            norm_sum = '0;
            norm_row = (row_a_inc >= i_cfg.height) ? '0 : row_a_inc[ROW_W-1:0];
        end
        col_inc = DIM_W'(r_lcol) + 1'b1;
        row_inc = DIM_W'(r_lrow) + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lrow      <= '0;
            r_lcol      <= '0;
            r_rowsum    <= '0;
        end else begin
            r_state <= n_state;
            if (out_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop_load) begin
                r_lrow   <= norm_row;
                r_lcol   <= norm_col;
                r_rowsum <= norm_sum;
            end else if (wr_en) begin
                if (col_inc >= i_cfg.width) begin
                    r_lcol   <= '0;
                    r_rowsum <= '0;
                    r_lrow   <= (row_inc >= i_cfg.height) ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    r_lcol   <= col_inc[COL_W-1:0];
                    r_rowsum <= r_rowsum + ROWSUM_W'(r_cmd.pw);
                end
            end
        end
    end

    // ---------------- corner accumulation and result register ----------------
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            S_QRD1:  r_acc <= rd_val;
            S_QRD2:  r_acc <= r_acc - rd_val;
            S_QRD3:  r_acc <= r_acc - rd_val;
            default: r_acc <= r_acc;
        endcase
        if (out_fire) begin
            r_out_sum <= r_cmd.oob ? '0 : r_acc + rd_val;
            r_out_oob <= r_cmd.oob;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_sum   = r_out_sum;
    assign o_out_of_image = r_out_oob;

    `IIWS_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, out_fire, r_out_valid)
    `IIWS_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, pop, r_state != S_IDLE)

endmodule

/* sv/integral_image_window_sum.sv */
// Top level of the summed-area table box sum block.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: i_func = 0 loads the
//   next gray pixel in raster order, i_func = 1 asks a window query at centre
//   (i_query_row, i_query_col). Loads give no result; every query gives one
//   result item on the output channel (o_out_valid / i_out_ready).
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set exponent,
//   image size and window size; the user must write them only while the block is idle (not enforced).
// Sequencing:
//   A two-entry queue sits between the front decode and the table engine. The
//   engine owns one single-port 64K x 32 table memory with a registered read.
//   Query: pop with the first corner read, three more corner reads, final add into the
//   result register (held while the output stalls). Centre outside the image: pop, then
//   result. Load: pop, read entry above, write. The engine pops only when idle.
// Reset: synchronous active low; clears pointers, row sum, queue and output
//   valid, and restores configuration defaults. The table is not cleared.
// Backpressure: the result register holds while i_out_ready is low; the engine
//   waits on it, the queue fills, then o_in_ready drops.
`timescale 1ns / 1ps
module integral_image_window_sum (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic [iiws_pkg::PIX_W-1:0]           i_pixel_value,
    input  logic [iiws_pkg::COORD_W-1:0]         i_query_row,
    input  logic [iiws_pkg::COORD_W-1:0]         i_query_col,
    // result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [iiws_pkg::SUM_BITS-1:0]        o_window_sum,
    output logic                                 o_out_of_image,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [iiws_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [iiws_pkg::DIM_W-1:0]           i_cfg_data
);
    import iiws_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    logic q_valid, q_ready;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    // Image sizes are clamped to 1..MAX when written; exponent codes whose low two bits
    // are not square all act as plain sum.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exp2   <= 1'b0;
            r_cfg.width  <= MAX_W_DIM;
            r_cfg.height <= MAX_H_DIM;
            r_cfg.half_w <= COORD_W'(1);
            r_cfg.half_h <= COORD_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EXPONENT:      r_cfg.exp2 <= (i_cfg_data[1:0] == EXP_SQUARE);
                CFG_IMAGE_WIDTH:   r_cfg.width <= (i_cfg_data == '0) ? DIM_W'(1) :
                                       (i_cfg_data > MAX_W_DIM) ? MAX_W_DIM : i_cfg_data;
                CFG_IMAGE_HEIGHT:  r_cfg.height <= (i_cfg_data == '0) ? DIM_W'(1) :
                                       (i_cfg_data > MAX_H_DIM) ? MAX_H_DIM : i_cfg_data;
                CFG_WINDOW_WIDTH:  r_cfg.half_w <= i_cfg_data[DIM_W-1:1];
                CFG_WINDOW_HEIGHT: r_cfg.half_h <= i_cfg_data[DIM_W-1:1];
                default: ;
            endcase
        end
    end

    iiws_front u_front (
        .i_cfg         (r_cfg),
        .i_func        (i_func),
        .i_pixel_value (i_pixel_value),
        .i_query_row   (i_query_row),
        .i_query_col   (i_query_col),
        .o_cmd         (front_cmd)
    );

    iiws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (front_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_cmd)
    );

    iiws_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .o_q_ready      (q_ready),
        .i_cmd          (q_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_window_sum   (o_window_sum),
        .o_out_of_image (o_out_of_image)
    );

endmodule
